@@ sv/laplacian_3d_stencil_defines.svh @@
// assertion macros shared by the stencil rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef LAPLACIAN_3D_STENCIL_DEFINES_SVH
`define LAPLACIAN_3D_STENCIL_DEFINES_SVH

// condition holds at every clock edge out of reset
`define LAP3_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LAP3_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LAP3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/lap3_pkg.sv @@
// shared constants, register indexes and the stage control struct of the stencil
// depends on nothing; used by the interfaces, lap3_sum and the top level
package lap3_pkg;

  // register field widths
  localparam int DIM_W     = 7;
  localparam int DZ_W      = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  // volume limits and reset values
  localparam int DZ_LIMIT  = 1024;
  localparam int RESET_DIM = 64;

  // parameter defaults
  localparam int DEF_MAX_X    = 64;
  localparam int DEF_MAX_Y    = 64;
  localparam int DEF_SAMPLE_W = 32;

  // guard bits of the result over the sample width
  localparam int OUT_GUARD = 4;

  // cycles for plane and volume size to follow a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // per-result control carried from the address stage to the arithmetic
  typedef struct packed {
    logic valid;
    logic need_l;
    logic need_r;
    logic need_yn;
    logic need_yp;
    logic need_zn;
    logic has_zp;
    logic first;
    logic fwd;
    logic last;
  } lap3_ctrl_t;

endpackage

@@ sv/lap3_stream_if.sv @@
// valid/ready stream interfaces for the voxel input and the result output
// depends on lap3_pkg for default widths
interface lap3_voxel_if #(
  parameter int SAMPLE_WIDTH = lap3_pkg::DEF_SAMPLE_W
);
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface lap3_result_if #(
  parameter int SAMPLE_WIDTH = lap3_pkg::DEF_SAMPLE_W
);
  logic                                                valid;
  logic                                                ready;
  logic signed [SAMPLE_WIDTH+lap3_pkg::OUT_GUARD-1:0] laplacian;
  logic                                                last;

  modport source (output valid, output laplacian, output last, input ready);
  modport sink   (input valid, input laplacian, input last, output ready);
endinterface

@@ sv/lap3_store.sv @@
// two-plane voxel store: two mirrored copies, one shared write, four registered reads
// depends on lap3_pkg for parameter defaults; instantiated by laplacian_3d_stencil
module lap3_store #(
  parameter int MAX_X        = lap3_pkg::DEF_MAX_X,
  parameter int MAX_Y        = lap3_pkg::DEF_MAX_Y,
  parameter int SAMPLE_WIDTH = lap3_pkg::DEF_SAMPLE_W
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 we,
  input  logic [$clog2(2*MAX_X*MAX_Y)-1:0]     waddr,
  input  logic signed [SAMPLE_WIDTH-1:0]       wdata,
  input  logic [$clog2(2*MAX_X*MAX_Y)-1:0]     raddr_a0,
  input  logic [$clog2(2*MAX_X*MAX_Y)-1:0]     raddr_a1,
  input  logic [$clog2(2*MAX_X*MAX_Y)-1:0]     raddr_b0,
  input  logic [$clog2(2*MAX_X*MAX_Y)-1:0]     raddr_b1,
  output logic signed [SAMPLE_WIDTH-1:0]       rdata_a0,
  output logic signed [SAMPLE_WIDTH-1:0]       rdata_a1,
  output logic signed [SAMPLE_WIDTH-1:0]       rdata_b0,
  output logic signed [SAMPLE_WIDTH-1:0]       rdata_b1
);
  localparam int DEPTH = 2 * MAX_X * MAX_Y;

  logic signed [SAMPLE_WIDTH-1:0] mem_a [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] mem_b [DEPTH];

  // reads return the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a0 <= mem_a[raddr_a0];
      rdata_a1 <= mem_a[raddr_a1];
      rdata_b0 <= mem_b[raddr_b0];
      rdata_b1 <= mem_b[raddr_b1];
    end
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
    end
  end
endmodule

@@ sv/lap3_sum.sv @@
// stencil arithmetic: centre pipe, two adder stages and the result register
// depends on lap3_pkg and lap3_result_if; instantiated by laplacian_3d_stencil
module lap3_sum #(
  parameter int SAMPLE_WIDTH = lap3_pkg::DEF_SAMPLE_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lap3_pkg::lap3_ctrl_t           ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] x_next,
  input  logic signed [SAMPLE_WIDTH-1:0] y_next,
  input  logic signed [SAMPLE_WIDTH-1:0] y_prev_or_first,
  input  logic signed [SAMPLE_WIDTH-1:0] z_prev,
  output logic                           advance,
  lap3_result_if.source                  results
);
  import lap3_pkg::*;

  localparam int OUT_W = SAMPLE_WIDTH + OUT_GUARD;

  function automatic logic signed [OUT_W-1:0] widen(input logic signed [SAMPLE_WIDTH-1:0] v);
    return {{OUT_GUARD{v[SAMPLE_WIDTH-1]}}, v};
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] c1;
  logic signed [SAMPLE_WIDTH-1:0] c2;
  logic signed [SAMPLE_WIDTH-1:0] centre;
  logic signed [SAMPLE_WIDTH-1:0] right;
  logic signed [OUT_W-1:0]        centre_w;
  logic signed [OUT_W-1:0]        sum_a_next;
  logic signed [OUT_W-1:0]        sum_b_next;
  logic signed [OUT_W-1:0]        six_c_next;

  logic                    v2;
  logic                    last2;
  logic signed [OUT_W-1:0] sum_a;
  logic signed [OUT_W-1:0] sum_b;
  logic signed [OUT_W-1:0] six_c;

  logic                    res_valid;
  logic signed [OUT_W-1:0] res_data;
  logic                    res_last;

  // whole pipe moves together while the result slot is free or taken
  assign advance = !res_valid || results.ready;

  // the first voxel of a volume comes straight from the store
  assign centre = ctrl.first ? y_prev_or_first : c1;
  assign right  = ctrl.fwd ? sample : x_next;

  // first adder stage: two partial neighbour sums and six times the centre
  always_comb begin
    centre_w   = widen(centre);
    sum_a_next = (ctrl.need_l  ? widen(c2)              : '0)
               + (ctrl.need_r  ? widen(right)           : '0)
               + (ctrl.need_yn ? widen(y_prev_or_first) : '0);
    sum_b_next = (ctrl.need_yp ? widen(y_next)          : '0)
               + (ctrl.need_zn ? widen(z_prev)          : '0)
               + (ctrl.has_zp  ? widen(sample)          : '0);
    six_c_next = (centre_w <<< 2) + (centre_w <<< 1);
  end

  // centre pipe: value at q and at q-1 for the next result
  always_ff @(posedge clk) begin
    if (advance && ctrl.valid) begin
      c1 <= right;
      c2 <= centre;
    end
  end

  // stage two control
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      last2 <= ctrl.last;
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
      six_c <= six_c_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= sum_a + sum_b - six_c;
      res_last <= last2;
    end
  end

  assign results.valid     = res_valid;
  assign results.laplacian = res_data;
  assign results.last      = res_last;
endmodule

@@ sv/laplacian_3d_stencil.sv @@
// top level of the streaming seven-point 3d laplacian
// depends on lap3_pkg, the stream interfaces, lap3_store, lap3_sum and the defines header
//
// Voxels arrive in raster order (x fastest) and the block takes one request every
// cycle, a push or a drain, as long as the result register is free or being taken.
// The result for a voxel leaves once the voxel one plane later has been pushed
// (or, for the final plane, once the drains have come), through the first pipe
// stage, the adder stage and the result register; drains flush the final plane one
// result per request. The rate is set by the voxel store: two mirrored copies with
// one write and two reads each give the four neighbour reads a result needs in one
// cycle, while the two x neighbours left of the newest read sit in a short centre
// register pipe. After a register write no voxel is taken until the plane and
// volume sizes have followed it. Store entries are never cleared: only entries
// written earlier in the same volume are read, so no clearing pass runs after reset.
`include "laplacian_3d_stencil_defines.svh"

module laplacian_3d_stencil #(
  parameter int MAX_X        = lap3_pkg::DEF_MAX_X,
  parameter int MAX_Y        = lap3_pkg::DEF_MAX_Y,
  parameter int SAMPLE_WIDTH = lap3_pkg::DEF_SAMPLE_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lap3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lap3_pkg::CFG_W-1:0]     cfg_data,
  lap3_voxel_if.sink                     voxels,
  lap3_result_if.source                  results
);
  import lap3_pkg::*;

  localparam int DEPTH   = 2 * MAX_X * MAX_Y;
  localparam int AW      = $clog2(DEPTH);
  localparam int PLANE_W = $clog2(MAX_X * MAX_Y + 1);
  localparam int POS_W   = $clog2(MAX_X * MAX_Y * DZ_LIMIT + 1);
  localparam int OZ_W    = $clog2(DZ_LIMIT);
  localparam int TOT_W   = PLANE_W + DZ_W;
  localparam int RST_X   = (RESET_DIM > MAX_X) ? MAX_X : RESET_DIM;
  localparam int RST_Y   = (RESET_DIM > MAX_Y) ? MAX_Y : RESET_DIM;

  function automatic logic [DZ_W-1:0] clamp_dim(input logic [DZ_W-1:0] v, input int hi);
    if (v == '0) return DZ_W'(1);
    if (int'(v) > hi) return DZ_W'(hi);
    return v;
  endfunction

  // reduce a sum below twice the store depth to a store address
  function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] sum);
    if (sum >= (AW+1)'(DEPTH)) return AW'(sum - (AW+1)'(DEPTH));
    return AW'(sum);
  endfunction

  // configuration and derived sizes
  logic [DIM_W-1:0]     dim_x;
  logic [DIM_W-1:0]     dim_y;
  logic [DZ_W-1:0]      dim_z;
  logic [PLANE_W-1:0]   plane;
  logic [POS_W-1:0]     total;
  logic [1:0]           settle;
  logic [2*DIM_W-1:0]   plane_prod;
  logic [TOT_W-1:0]     total_prod;
  logic                 cfg_hit;

  // stream positions
  logic [POS_W-1:0]     p;
  logic [POS_W-1:0]     q;
  logic [AW-1:0]        pa;
  logic [AW-1:0]        qa;
  logic [DIM_W-1:0]     ox;
  logic [DIM_W-1:0]     oy;
  logic [OZ_W-1:0]      oz;

  // request decode
  logic                 advance;
  logic                 accept;
  logic                 push_ok;
  logic                 push_emit;
  logic                 drain_emit;
  logic                 emit;
  logic                 last_hit;
  logic [DIM_W-1:0]     ox_inc;
  logic [DIM_W-1:0]     oy_inc;
  logic [AW-1:0]        pa_inc;
  logic [AW-1:0]        qa_inc;
  logic [AW-1:0]        addr_a1;
  logic [AW-1:0]        addr_b0;
  logic [AW-1:0]        addr_b1;
  lap3_ctrl_t           s0_ctrl;

  // first pipe stage
  lap3_ctrl_t                     s1_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic signed [SAMPLE_WIDTH-1:0] rd_a0;
  logic signed [SAMPLE_WIDTH-1:0] rd_a1;
  logic signed [SAMPLE_WIDTH-1:0] rd_b0;
  logic signed [SAMPLE_WIDTH-1:0] rd_b1;

  // sizes follow the registers one multiply per cycle
  assign plane_prod = (2*DIM_W)'(dim_x) * (2*DIM_W)'(dim_y);
  assign total_prod = TOT_W'(plane) * TOT_W'(dim_z);

  always_ff @(posedge clk) begin
    plane <= PLANE_W'(plane_prod);
    total <= POS_W'(total_prod);
  end

  // register index decode
  always_comb begin
    case (cfg_index)
      REG_DIM_X, REG_DIM_Y, REG_DIM_Z: cfg_hit = cfg_write;
      default:                         cfg_hit = 1'b0;
    endcase
  end

  // request decode
  assign voxels.ready = advance && (settle == '0);
  assign accept       = voxels.valid && voxels.ready;
  assign push_ok      = accept && !voxels.mode && (p < total);
  assign push_emit    = push_ok && (p >= POS_W'(plane));
  assign drain_emit   = accept && voxels.mode && (p == total);
  assign emit         = push_emit || drain_emit;
  assign last_hit     = (q + POS_W'(1)) == total;

  assign ox_inc = ox + DIM_W'(1);
  assign oy_inc = oy + DIM_W'(1);

  // store addresses, all kept modulo the store depth
  assign pa_inc  = (pa == AW'(DEPTH - 1)) ? '0 : pa + AW'(1);
  assign qa_inc  = (qa == AW'(DEPTH - 1)) ? '0 : qa + AW'(1);
  assign addr_a1 = wrap_addr({1'b0, qa} + (AW+1)'(dim_y == DIM_W'(1) ? '0 : dim_x));
  assign addr_b0 = (q == '0) ? qa
                 : wrap_addr({1'b0, qa} + (AW+1)'(DEPTH) - (AW+1)'(dim_x));
  assign addr_b1 = wrap_addr({1'b0, qa} + (AW+1)'(DEPTH) - (AW+1)'(plane));

  // neighbour selection for the result of voxel q
  always_comb begin
    s0_ctrl.valid   = emit;
    s0_ctrl.need_l  = ox != '0;
    s0_ctrl.need_r  = ox_inc < dim_x;
    s0_ctrl.need_yn = oy != '0;
    s0_ctrl.need_yp = oy_inc < dim_y;
    s0_ctrl.need_zn = oz != '0;
    s0_ctrl.has_zp  = push_emit;
    s0_ctrl.first   = q == '0;
    s0_ctrl.fwd     = push_ok && ((q + POS_W'(1)) == p);
    s0_ctrl.last    = last_hit;
  end

  // registers and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x  <= DIM_W'(RST_X);
      dim_y  <= DIM_W'(RST_Y);
      dim_z  <= DZ_W'(RESET_DIM);
      settle <= SETTLE_CYCLES;
      p      <= '0;
      q      <= '0;
      pa     <= '0;
      qa     <= '0;
      ox     <= '0;
      oy     <= '0;
      oz     <= '0;
    end else begin
      if (settle != '0) begin
        settle <= settle - 2'd1;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_DIM_X: dim_x <= DIM_W'(clamp_dim(DZ_W'(cfg_data[DIM_W-1:0]), MAX_X));
          REG_DIM_Y: dim_y <= DIM_W'(clamp_dim(DZ_W'(cfg_data[DIM_W-1:0]), MAX_Y));
          REG_DIM_Z: dim_z <= clamp_dim(cfg_data[DZ_W-1:0], DZ_LIMIT);
          default: ;
        endcase
      end
      if (cfg_hit) begin
        settle <= SETTLE_CYCLES;
        p      <= '0;
        q      <= '0;
        pa     <= '0;
        qa     <= '0;
        ox     <= '0;
        oy     <= '0;
        oz     <= '0;
      end else begin
        if (push_ok) begin
          p  <= p + POS_W'(1);
          pa <= pa_inc;
        end
        if (emit) begin
          if (last_hit) begin
            p  <= '0;
            q  <= '0;
            pa <= '0;
            qa <= '0;
            ox <= '0;
            oy <= '0;
            oz <= '0;
          end else begin
            q  <= q + POS_W'(1);
            qa <= qa_inc;
            if (ox_inc == dim_x) begin
              ox <= '0;
              if (oy_inc == dim_y) begin
                oy <= '0;
                oz <= oz + OZ_W'(1);
              end else begin
                oy <= oy_inc;
              end
            end else begin
              ox <= ox_inc;
            end
          end
        end
      end
    end
  end

  // first pipe stage control, aligned with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (advance) begin
      s1_ctrl <= s0_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sample <= voxels.sample;
    end
  end

  // voxel store
  lap3_store #(
    .MAX_X        (MAX_X),
    .MAX_Y        (MAX_Y),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_store (
    .clk      (clk),
    .en       (advance),
    .we       (push_ok),
    .waddr    (pa),
    .wdata    (voxels.sample),
    .raddr_a0 (qa_inc),
    .raddr_a1 (addr_a1),
    .raddr_b0 (addr_b0),
    .raddr_b1 (addr_b1),
    .rdata_a0 (rd_a0),
    .rdata_a1 (rd_a1),
    .rdata_b0 (rd_b0),
    .rdata_b1 (rd_b1)
  );

  // arithmetic and result register
  lap3_sum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_sum (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (s1_ctrl),
    .sample          (s1_sample),
    .x_next          (rd_a0),
    .y_next          (rd_a1),
    .y_prev_or_first (rd_b0),
    .z_prev          (rd_b1),
    .advance         (advance),
    .results         (results)
  );

  // checks on the position tracking
  `LAP3_ASSERT_ALWAYS(a_out_behind_in, clk, rst, q <= p, "output position passed input position")
  `LAP3_ASSERT_IMPLY(a_in_in_volume, clk, rst, settle == '0, p <= total, "input position beyond volume")
  `LAP3_ASSERT_IMPLY(a_push_lag, clk, rst, push_emit, (q + POS_W'(plane)) == p, "push result not one plane behind")
  `LAP3_ASSERT_NEXT(a_volume_wrap, clk, rst, emit && last_hit, (p == '0) && (q == '0), "positions kept after final result")
endmodule

@@ dv/lap3_tb_pkg.sv @@
// request mode codes shared by the stencil testbench top and its checker
// depends on nothing; compiled after the rtl package and before the checker
package lap3_tb_pkg;

  // request kinds on the voxel channel
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

endpackage

@@ dv/lap3_stencil_checker.sv @@
// checker for the streaming 3d laplacian: predicts every result and compares it
// depends on lap3_pkg, lap3_tb_pkg and the voxel and result stream interfaces
module lap3_stencil_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lap3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lap3_pkg::CFG_W-1:0]     cfg_data,
  lap3_voxel_if                          voxels,
  lap3_result_if                         results,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lap3_pkg::*;
  import lap3_tb_pkg::*;

  localparam int          SW             = DEF_SAMPLE_W;
  localparam int          RW             = DEF_SAMPLE_W + OUT_GUARD;
  localparam int unsigned STORE_D        = 2 * DEF_MAX_X * DEF_MAX_Y;
  localparam longint      CENTRE_WEIGHT  = 6;
  localparam int          REPORT_LIMIT   = 10;

  typedef struct packed {
    logic signed [RW-1:0] lap;
    logic                 last;
  } lap_result_t;

  // predictor state: two planes of voxels, volume geometry and stream positions
  logic signed [SW-1:0] voxel_mem [STORE_D];
  int unsigned          dim_x, dim_y, dim_z;
  int unsigned          in_pos, out_pos;
  lap_result_t          lap_q [$];

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint voxel_at(input int unsigned pos);
    return longint'(voxel_mem[pos % STORE_D]);
  endfunction

  // register write restarts the volume
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_DIM_X: dim_x = clamp_dim(data[DIM_W-1:0], DEF_MAX_X);
      REG_DIM_Y: dim_y = clamp_dim(data[DIM_W-1:0], DEF_MAX_Y);
      REG_DIM_Z: dim_z = clamp_dim(data[DZ_W-1:0], DZ_LIMIT);
      default: return;
    endcase
    in_pos  = 0;
    out_pos = 0;
  endtask

  // laplacian of voxel q; the +z neighbour comes with the request when present
  task automatic emit_result(input int unsigned q, input bit has_zp, input longint zp);
    int unsigned plane, total, x, y, z;
    longint      acc;
    lap_result_t r;
    plane = dim_x * dim_y;
    total = plane * dim_z;
    x     = q % dim_x;
    y     = (q / dim_x) % dim_y;
    z     = q / plane;
    acc   = 0;
    if (x > 0) acc += voxel_at(q - 1);
    if (x + 1 < dim_x) acc += voxel_at(q + 1);
    if (y > 0) acc += voxel_at(q - dim_x);
    if (y + 1 < dim_y) acc += voxel_at(q + dim_x);
    if (z > 0) acc += voxel_at(q - plane);
    if (z + 1 < dim_z && has_zp) acc += zp;
    acc -= CENTRE_WEIGHT * voxel_at(q);
    r.lap  = acc[RW-1:0];
    r.last = (q + 1 == total);
    lap_q.push_back(r);
    out_pos = q + 1;
    if (out_pos == total) begin
      in_pos  = 0;
      out_pos = 0;
    end
  endtask

  task automatic predict_request(input logic mode, input logic signed [SW-1:0] sample);
    int unsigned plane, total, p;
    bit          made;
    plane = dim_x * dim_y;
    total = plane * dim_z;
    made  = 1'b0;
    if (mode == MODE_PUSH) begin
      p = in_pos;
      // pushes past the end of the volume are dropped
      if (p >= total) return;
      if (p >= plane) begin
        emit_result(p - plane, 1'b1, longint'(sample));
        made = 1'b1;
      end
      // write after the reads: the slot may hold the voxel two planes back
      voxel_mem[p % STORE_D] = sample;
      if (!(made && out_pos == 0)) in_pos = p + 1;
    end else if (in_pos == total && out_pos < total) begin
      emit_result(out_pos, 1'b0, 0);
    end
  endtask

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // predict on every accepted request, compare on every accepted result
  always @(posedge clk) begin
    lap_result_t want;
    if (rst) begin
      lap_q.delete();
      dim_x   = RESET_DIM;
      dim_y   = RESET_DIM;
      dim_z   = RESET_DIM;
      in_pos  = 0;
      out_pos = 0;
      foreach (voxel_mem[i]) voxel_mem[i] = '0;
    end else begin
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      if (voxels.valid && voxels.ready) predict_request(voxels.mode, voxels.sample);
      if (results.valid && results.ready) begin
        if (lap_q.size() == 0) begin
          note_failure($sformatf("unexpected result laplacian %0d last %0b",
                                 results.laplacian, results.last));
        end else begin
          want = lap_q.pop_front();
          if (want.lap !== results.laplacian || want.last !== results.last) begin
            note_failure($sformatf("expected laplacian %0d last %0b, got %0d last %0b",
                                   $signed(want.lap), want.last,
                                   results.laplacian, results.last));
          end
        end
      end
    end
    pending <= lap_q.size();
  end

endmodule

@@ dv/tb_laplacian_3d_stencil.sv @@
// testbench top for the streaming 3d laplacian: clock, reset, stimulus and verdict
// depends on lap3_pkg, lap3_tb_pkg, the stream interfaces, the rtl and lap3_stencil_checker
module tb_laplacian_3d_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  import lap3_pkg::*;
  import lap3_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 8;
  localparam int LONG_HOLD    = 300;
  localparam int NOISE_ODDS   = 24;

  localparam logic signed [DEF_SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [DEF_SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int cycles    = 0;
  int mismatches;
  int results_owed;

  lap3_voxel_if  vox_ch ();
  lap3_result_if res_ch ();

  laplacian_3d_stencil uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .voxels    (vox_ch),
    .results   (res_ch)
  );

  lap3_stencil_checker lap_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .voxels    (vox_ch),
    .results   (res_ch),
    .errors    (mismatches),
    .pending   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls plus one long hold per toggle of hold_req
  initial begin : result_taker
    int hold_left;
    bit hold_seen;
    hold_left    = 0;
    hold_seen    = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [DEF_SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return $signed($urandom_range(511)) - 256;
      default: return $urandom;
    endcase
  endfunction

  // offer one request, with an optional random gap before it
  task automatic send_request(input logic m, input logic signed [DEF_SAMPLE_W-1:0] s);
    if ($urandom_range(99) < idle_pct) begin
      vox_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    vox_ch.valid  <= 1'b1;
    vox_ch.mode   <= m;
    vox_ch.sample <= s;
    do @(posedge clk); while (!vox_ch.ready);
  endtask

  // stop offering and wait until every owed result has come out
  task automatic quiesce();
    vox_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(input int wx, input int wy, input int wz);
    cfg_write <= 1'b1;
    cfg_index <= REG_DIM_X;
    cfg_data  <= CFG_W'(wx);
    @(posedge clk);
    cfg_index <= REG_DIM_Y;
    cfg_data  <= CFG_W'(wy);
    @(posedge clk);
    cfg_index <= REG_DIM_Z;
    cfg_data  <= CFG_W'(wz);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one volume of random voxels, then the drains; stray requests mixed in,
  // sometimes cut short so the next register write restarts mid volume
  task automatic run_volume(input int wx, input int wy, input int wz, input bit may_abort);
    int unsigned plane, total, stop_at;
    quiesce();
    write_regs(wx, wy, wz);
    plane   = eff_dim(wx & 'h7f, DEF_MAX_X) * eff_dim(wy & 'h7f, DEF_MAX_Y);
    total   = plane * eff_dim(wz & 'h7ff, DZ_LIMIT);
    stop_at = total;
    if (may_abort && $urandom_range(9) == 0) stop_at = $urandom_range(total - 1);
    for (int unsigned i = 0; i < stop_at; i++) begin
      if ($urandom_range(NOISE_ODDS) == 0) send_request(MODE_DRAIN, rand_sample());
      send_request(MODE_PUSH, rand_sample());
    end
    if (stop_at == total) begin
      for (int unsigned i = 0; i < plane; i++) begin
        if ($urandom_range(NOISE_ODDS) == 0) send_request(MODE_PUSH, rand_sample());
        send_request(MODE_DRAIN, rand_sample());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned x, y, z;
    vox_ch.valid  = 1'b0;
    vox_ch.mode   = MODE_PUSH;
    vox_ch.sample = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: first plane only, so nothing comes out yet
    send_request(MODE_PUSH, SAMPLE_MAX);
    send_request(MODE_PUSH, SAMPLE_MIN);
    send_request(MODE_PUSH, '0);

    // 2x3x2 checkerboard of extremes, early drain, late push and late drain
    quiesce();
    write_regs(2, 3, 2);
    send_request(MODE_DRAIN, '0);
    for (int unsigned v = 0; v < 12; v++) begin
      x = v % 2;
      y = (v / 2) % 3;
      z = v / 6;
      send_request(MODE_PUSH, ((x + y + z) % 2 == 1) ? SAMPLE_MAX : SAMPLE_MIN);
    end
    send_request(MODE_PUSH, SAMPLE_MAX);
    repeat (6) send_request(MODE_DRAIN, '0);
    send_request(MODE_DRAIN, '0);

    // random phases with different idle patterns, extreme geometries among them
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
          hold_req  <= ~hold_req;
          run_volume(1, 1, 2047, 1'b0);
        end
        1: begin
          idle_pct  = 81;
          stall_pct <= 0;
          run_volume(127, 1, 1, 1'b0);
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 81;
          run_volume(1, 127, 1, 1'b0);
        end
        default: begin
          idle_pct  = 37;
          stall_pct <= 37;
          hold_req  <= ~hold_req;
          run_volume(0, 0, 0, 1'b0);
        end
      endcase
      repeat (2) begin
        run_volume($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(1, 4), 1'b1);
      end
    end

    quiesce();
    if (mismatches == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/lap3_pkg.sv
sv/lap3_stream_if.sv
sv/lap3_store.sv
sv/lap3_sum.sv
sv/laplacian_3d_stencil.sv
dv/lap3_tb_pkg.sv
dv/lap3_stencil_checker.sv
dv/tb_laplacian_3d_stencil.sv
